>>> design/hct_pkg.sv
`default_nettype none

package hct_pkg;

    // Default sizes of the tree store.
    localparam int NodeCountDef  = 512;
    localparam int MaxCodeLenDef = 15;
    localparam int SymbolBitsDef = 9;

    // Widths of the item fields.
    localparam int ModeW     = 2;
    localparam int CodeBitsW = 16;
    localparam int CodeLenW  = 4;
    localparam int SymInW    = 9;
    localparam int StatusW   = 3;
    localparam int SymOutW   = 9;

    // Stream word layout.
    localparam int InDataW  = 32;
    localparam int OutDataW = 16;
    localparam int CodeLsb  = 0;
    localparam int LenLsb   = CodeLsb + CodeBitsW;
    localparam int SymLsb   = LenLsb + CodeLenW;
    localparam int BitLsb   = SymLsb + SymInW;

    typedef enum logic [ModeW-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DECODE = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    // Contents of one branch of a node.
    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_NODE  = 2'd1,
        KIND_LEAF  = 2'd2
    } t_kind;

    typedef enum logic [StatusW-1:0] {
        ST_INSERTED = 3'd0,
        ST_SYMBOL   = 3'd1,
        ST_BAD_LEN  = 3'd2,
        ST_AMBIG    = 3'd3,
        ST_INVALID  = 3'd4,
        ST_FULL     = 3'd5,
        ST_CLEARED  = 3'd6
    } t_status;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_ARM,
        OP_STEP,
        OP_STOP,
        OP_WRITE,
        OP_DEC,
        OP_CLEAR
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    emit;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic bad_len;
        logic conflict;
        logic stop;
        logic full;
        logic last;
        logic dec_node;
        logic dec_leaf;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> design/hct_ram.sv
`default_nettype none

module hct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> design/hct_ctrl.sv
`default_nettype none

module hct_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    input  wire logic [hct_pkg::ModeW-1:0]   i_mode,
    output logic                             o_s_tready,
    input  wire hct_pkg::t_dp_stat           i_stat,
    output hct_pkg::t_dp_cmd                 o_cmd
);

    import hct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FULL,
        S_COMMIT,
        S_DEC
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;
    logic    accept;

    assign o_s_tready = (r_state == S_IDLE) && i_stat.out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    // Next state and datapath command.
    always_comb begin
        n_state    = r_state;
        cmd.op     = OP_NONE;
        cmd.emit   = 1'b0;
        cmd.status = ST_INSERTED;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_mode'(i_mode))
                        MODE_INSERT: begin
                            if (i_stat.bad_len) begin
                                cmd.emit   = 1'b1;
                                cmd.status = ST_BAD_LEN;
                            end else begin
                                cmd.op  = OP_LOAD;
                                n_state = S_WALK;
                            end
                        end
                        MODE_DECODE: begin
                            cmd.op  = OP_ARM;
                            n_state = S_DEC;
                        end
                        MODE_CLEAR: begin
                            cmd.op     = OP_CLEAR;
                            cmd.emit   = 1'b1;
                            cmd.status = ST_CLEARED;
                        end
                        default: begin
                            cmd.op = OP_NONE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (i_stat.conflict) begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_AMBIG;
                    n_state    = S_IDLE;
                end else if (i_stat.stop) begin
                    cmd.op  = OP_STOP;
                    n_state = S_FULL;
                end else begin
                    cmd.op = OP_STEP;
                end
            end
            S_FULL: begin
                if (i_stat.full) begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_FULL;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd.op = OP_WRITE;
                if (i_stat.last) begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_INSERTED;
                    n_state    = S_IDLE;
                end
            end
            S_DEC: begin
                cmd.op = OP_DEC;
                if (!i_stat.dec_node) begin
                    cmd.emit   = 1'b1;
                    cmd.status = i_stat.dec_leaf ? ST_SYMBOL : ST_INVALID;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    // A result is only produced when the output register can take it.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> i_stat.out_free)
        else $error("result produced while output register busy");

    // A commit sequence always follows a passed fullness check.
    a_commit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> ($past(r_state) == S_FULL || $past(r_state) == S_COMMIT))
        else $error("commit entered without fullness check");

    // Nothing is accepted while an item is in progress.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_tready)
        else $error("ready raised during an item");
`endif

endmodule

`default_nettype wire

>>> design/hct_dp.sv
`default_nettype none

module hct_dp #(
    parameter int NODE_COUNT   = hct_pkg::NodeCountDef,
    parameter int MAX_CODE_LEN = hct_pkg::MaxCodeLenDef,
    parameter int SYMBOL_BITS  = hct_pkg::SymbolBitsDef
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [hct_pkg::InDataW-1:0]   i_s_tdata,
    input  wire hct_pkg::t_dp_cmd              i_cmd,
    output hct_pkg::t_dp_stat                  o_stat,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [hct_pkg::OutDataW-1:0]       o_m_tdata,
    output logic [hct_pkg::StatusW-1:0]        o_m_tuser
);

    import hct_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);
    localparam int CW = AW + 1;
    localparam int SB = SYMBOL_BITS;
    localparam int VW = (AW > SB) ? AW : SB;
    localparam int BW = 2 + VW;
    localparam int RW = 2 * BW;
    localparam int SW = CW + 5;
    localparam logic [4:0]    MaxLen   = 5'(MAX_CODE_LEN);
    localparam logic [SW-1:0] NodeLim  = SW'(NODE_COUNT);

    // Input fields.
    logic [CodeBitsW-1:0] in_code;
    logic [CodeLenW-1:0]  in_len;
    logic [SymInW-1:0]    in_sym;
    logic                 in_bit;
    logic [SB+SymInW-1:0] in_sym_wide;

    assign in_code     = i_s_tdata[CodeLsb +: CodeBitsW];
    assign in_len      = i_s_tdata[LenLsb +: CodeLenW];
    assign in_sym      = i_s_tdata[SymLsb +: SymInW];
    assign in_bit      = i_s_tdata[BitLsb];
    assign in_sym_wide = {{SB{1'b0}}, in_sym};

    // Working registers.
    logic [CodeBitsW-1:0] r_code;
    logic [CodeLenW-1:0]  r_len;
    logic [SB-1:0]        r_sym;
    logic                 r_bit;
    logic [AW-1:0]        r_node;
    logic [CodeLenW-1:0]  r_level;
    logic [RW-1:0]        r_row;
    logic [CW-1:0]        r_alloc;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_walk;
    logic                 r_rd_ok;
    logic                 r_out_valid;
    t_status              r_status;
    logic [SymOutW-1:0]   r_symout;

    // Node store.
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [RW-1:0] wr_data;
    logic [RW-1:0] rd_data;

    hct_ram #(
        .WIDTH (RW),
        .DEPTH (NODE_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_node),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Rows at or above the fill count read as empty.
    logic [RW-1:0] row;
    logic          wbit;
    logic [BW-1:0] wbr;
    logic [BW-1:0] dbr;
    t_kind         wk;
    t_kind         dk;
    logic [VW-1:0] wval;
    logic [VW-1:0] dval;
    logic          last;

    assign row  = r_rd_ok ? rd_data : '0;
    assign wbit = r_code[r_level];
    assign wbr  = wbit ? row[RW-1:BW] : row[BW-1:0];
    assign dbr  = r_bit ? row[RW-1:BW] : row[BW-1:0];
    assign wk   = t_kind'(wbr[BW-1:VW]);
    assign dk   = t_kind'(dbr[BW-1:VW]);
    assign wval = wbr[VW-1:0];
    assign dval = dbr[VW-1:0];
    assign last = (r_level == r_len - CodeLenW'(1));

    // Read address follows the walk.
    always_comb begin
        case (i_cmd.op)
            OP_LOAD: rd_addr = '0;
            OP_STEP: rd_addr = wval[AW-1:0];
            default: rd_addr = r_walk;
        endcase
    end

    // Branch written during commit: a new inner node or the final leaf.
    logic [BW-1:0] new_br;

    assign new_br  = last ? {KIND_LEAF, VW'(r_sym)} : {KIND_NODE, VW'(r_alloc[AW-1:0])};
    assign wr_data = wbit ? {new_br, r_row[BW-1:0]} : {r_row[RW-1:BW], new_br};
    assign wr_en   = (i_cmd.op == OP_WRITE);

    // Status toward the controller.
    logic [SW-1:0] need_sum;
    logic [SB+SymOutW-1:0] dsym_wide;

    assign need_sum  = SW'(r_alloc) + SW'(r_len - CodeLenW'(1) - r_level);
    assign dsym_wide = {{SymOutW{1'b0}}, dval[SB-1:0]};

    always_comb begin
        o_stat.bad_len  = (in_len == '0) || ({1'b0, in_len} > MaxLen)
                          || ((in_code >> in_len) != '0);
        o_stat.conflict = last ? ((wk == KIND_NODE)
                                  || (wk == KIND_LEAF && wval != VW'(r_sym)))
                               : (wk == KIND_LEAF);
        o_stat.stop     = last || (wk == KIND_EMPTY);
        o_stat.full     = need_sum > NodeLim;
        o_stat.last     = last;
        o_stat.dec_node = (dk == KIND_NODE);
        o_stat.dec_leaf = (dk == KIND_LEAF);
        o_stat.out_free = !r_out_valid || i_m_tready;
    end

    // Control registers: fill count, decode pointer, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_CLEAR: begin
                    r_count <= '0;
                    r_walk  <= '0;
                end
                OP_WRITE: begin
                    if (last) begin
                        r_count <= r_alloc;
                    end
                end
                OP_DEC: begin
                    r_walk <= (dk == KIND_NODE) ? dval[AW-1:0] : '0;
                end
                default: begin
                    r_walk <= r_walk;
                end
            endcase
        end
    end

    // Payload registers of the walk and the result word.
    always_ff @(posedge i_clk) begin
        r_rd_ok <= ({1'b0, rd_addr} < r_count);
        if (i_cmd.emit) begin
            r_status <= i_cmd.status;
            r_symout <= (i_cmd.status == ST_SYMBOL) ? dsym_wide[SymOutW-1:0] : '0;
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_code  <= in_code;
                r_len   <= in_len;
                r_sym   <= in_sym_wide[SB-1:0];
                r_node  <= '0;
                r_level <= '0;
            end
            OP_ARM: begin
                r_bit <= in_bit;
            end
            OP_STEP: begin
                r_node  <= wval[AW-1:0];
                r_level <= r_level + CodeLenW'(1);
            end
            OP_STOP: begin
                r_row   <= row;
                r_alloc <= (r_count == '0) ? CW'(1) : r_count;
            end
            OP_WRITE: begin
                if (!last) begin
                    r_node  <= r_alloc[AW-1:0];
                    r_alloc <= r_alloc + CW'(1);
                    r_level <= r_level + CodeLenW'(1);
                    r_row   <= '0;
                end
            end
            default: begin
                r_level <= r_level;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OutDataW-SymOutW){1'b0}}, r_symout};
    assign o_m_tuser  = r_status;

`ifndef NO_ASSERTIONS
    // The fill count never passes the store size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NODE_COUNT))
        else $error("node count beyond store size");

    // Commit writes only go to nodes already allocated.
    a_write_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ({1'b0, r_node} < r_alloc))
        else $error("write to an unallocated node");

    // The decode pointer stays on the root or on an allocated node.
    a_walk_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_walk == '0) || ({1'b0, r_walk} < r_count))
        else $error("decode pointer outside allocated nodes");
`endif

endmodule

`default_nettype wire

>>> design/huffman_code_tree_table.sv
// Channel   Dir  Handshake                 tdata / tuser
// s         in   i_s_tvalid / o_s_tready   code, length, symbol, stream bit / mode
// m         out  o_m_tvalid / i_m_tready   decoded symbol / status
//
// Clear, unused mode and bad length finish in the idle state; a decode bit also
// passes the decode state. An insert walks existing nodes, checks room, then
// commits rows, with one node-store read per level and one row write per cycle.
// Reset is synchronous, active low; the node store needs no clearing pass, since
// a fill count marks which rows hold data. Input is taken only while the output
// word is free or being taken in the same cycle.
`default_nettype none

module huffman_code_tree_table #(
    parameter int NODE_COUNT   = hct_pkg::NodeCountDef,
    parameter int MAX_CODE_LEN = hct_pkg::MaxCodeLenDef,
    parameter int SYMBOL_BITS  = hct_pkg::SymbolBitsDef
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // code_bits[15:0], code_len[19:16], symbol_in[28:20], stream_bit[29], zero fill
    input  wire logic [hct_pkg::InDataW-1:0] i_s_tdata,
    // mode[1:0]
    input  wire logic [hct_pkg::ModeW-1:0]   i_s_tuser,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // symbol_out[8:0], zero fill
    output logic [hct_pkg::OutDataW-1:0]     o_m_tdata,
    // status[2:0]
    output logic [hct_pkg::StatusW-1:0]      o_m_tuser
);

    import hct_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    hct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_mode     (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hct_dp #(
        .NODE_COUNT   (NODE_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_BITS  (SYMBOL_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hct_pkg::*;

    // Mode value that the block ignores.
    localparam logic [ModeW-1:0] ModeUnused = 2'd3;
    // Receiver hold-off that backs the block up, in cycles.
    localparam int HoldCycles = 300;
    // Cycles without any accepted word before the run is abandoned.
    localparam int StallLimit = 3000;
    // Cycles to wait after the last result.
    localparam int TailCycles = 40;
    localparam int KnownMax   = 40;

    // One input word, fields as they sit in tdata and tuser.
    typedef struct packed {
        logic [ModeW-1:0]     mode;
        logic                 stream_bit;
        logic [SymInW-1:0]    sym;
        logic [CodeLenW-1:0]  len;
        logic [CodeBitsW-1:0] code;
    } t_tree_word;

    // One result word.
    typedef struct packed {
        t_status            status;
        logic [SymOutW-1:0] symbol;
    } t_tree_result;

    // A code that the stimulus has tried to insert.
    typedef struct packed {
        logic [CodeBitsW-1:0] code;
        logic [CodeLenW-1:0]  len;
        logic [SymInW-1:0]    sym;
    } t_code_ref;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    // code_bits[15:0], code_len[19:16], symbol_in[28:20], stream_bit[29], zero fill
    logic [InDataW-1:0]   i_s_tdata  = '0;
    // mode[1:0]
    logic [ModeW-1:0]     i_s_tuser  = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // symbol_out[8:0], zero fill
    logic [OutDataW-1:0]  o_m_tdata;
    // status[2:0]
    logic [StatusW-1:0]   o_m_tuser;

    huffman_code_tree_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Predicted contents of the code tree.
    t_kind              tree_kind [NodeCountDef][2];
    logic [SymOutW-1:0] tree_val  [NodeCountDef][2];
    int unsigned        tree_used;
    int unsigned        walk_ptr;

    t_tree_word   pending_words [$];
    t_tree_result results_due [$];
    t_code_ref    known_codes [$];

    int words_queued   = 0;
    int words_accepted = 0;
    int stim_count     = 0;
    int results_seen   = 0;
    int err_cnt        = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_done      = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    int status_seen [8];

    function automatic void tree_clear();
        int n;
        for (n = 0; n < NodeCountDef; n++) begin
            tree_kind[n][0] = KIND_EMPTY;
            tree_kind[n][1] = KIND_EMPTY;
            tree_val[n][0]  = '0;
            tree_val[n][1]  = '0;
        end
        tree_used = 0;
        walk_ptr  = 0;
    endfunction

    // Walks the code LSB first; a dry pass finds conflicts and counts new nodes,
    // and only a clean insert changes the tree.
    function automatic t_status tree_insert(int unsigned code, int unsigned len,
                                            logic [SymInW-1:0] sym_in);
        int unsigned i, b, node, need;
        bit fresh, last;
        t_kind k;
        logic [SymOutW-1:0] sym;
        sym = SymOutW'(sym_in);
        if (len == 0 || len > MaxCodeLenDef || (code >> len) != 0)
            return ST_BAD_LEN;
        node  = 0;
        fresh = (tree_used == 0);
        need  = fresh ? 1 : 0;
        for (i = 0; i < len; i++) begin
            b    = (code >> i) & 1;
            last = (i == len - 1);
            if (fresh) begin
                if (!last)
                    need++;
            end else begin
                k = tree_kind[node][b];
                if (last) begin
                    if (k == KIND_NODE || (k == KIND_LEAF && tree_val[node][b] != sym))
                        return ST_AMBIG;
                end else if (k == KIND_LEAF) begin
                    return ST_AMBIG;
                end else if (k == KIND_EMPTY) begin
                    fresh = 1'b1;
                    need++;
                end else begin
                    node = tree_val[node][b];
                end
            end
        end
        if (tree_used + need > NodeCountDef)
            return ST_FULL;

        if (tree_used == 0)
            tree_used = 1;
        node = 0;
        for (i = 0; i < len; i++) begin
            b = (code >> i) & 1;
            if (i == len - 1) begin
                tree_kind[node][b] = KIND_LEAF;
                tree_val[node][b]  = sym;
            end else if (tree_kind[node][b] == KIND_EMPTY) begin
                tree_kind[node][b] = KIND_NODE;
                tree_val[node][b]  = SymOutW'(tree_used);
                node = tree_used;
                tree_used++;
            end else begin
                node = tree_val[node][b];
            end
        end
        return ST_INSERTED;
    endfunction

    // Applies one accepted word to the predicted tree; returns 1 when it gives a result.
    function automatic bit tree_step(input t_tree_word w, output t_tree_result r);
        int unsigned n, b;
        t_kind k;
        r.status = ST_CLEARED;
        r.symbol = '0;
        case (w.mode)
            MODE_INSERT: begin
                r.status = tree_insert(w.code, w.len, w.sym);
            end
            MODE_DECODE: begin
                n = walk_ptr;
                b = w.stream_bit;
                k = tree_kind[n][b];
                if (k == KIND_NODE) begin
                    walk_ptr = tree_val[n][b];
                    return 1'b0;
                end
                walk_ptr = 0;
                if (k == KIND_LEAF) begin
                    r.status = ST_SYMBOL;
                    r.symbol = tree_val[n][b];
                end else begin
                    r.status = ST_INVALID;
                end
            end
            MODE_CLEAR: begin
                tree_clear();
                r.status = ST_CLEARED;
            end
            default: begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    // Sender: offers queued words and predicts each one as it is taken.
    always @(posedge i_clk) begin : send_side
        t_tree_result res;
        t_tree_word   cur_word;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                words_accepted++;
                if (tree_step(cur_word, res))
                    results_due.push_back(res);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word = pending_words.pop_front();
                    i_s_tdata <= {{(InDataW - BitLsb - 1){1'b0}}, cur_word.stream_bit,
                                  cur_word.sym, cur_word.len, cur_word.code};
                    i_s_tuser  <= cur_word.mode;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result word against the oldest prediction.
    always @(posedge i_clk) begin : recv_side
        t_tree_result due;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                status_seen[o_m_tuser]++;
                if (results_due.size() == 0) begin
                    $error("unexpected result word: status %0d symbol_out %0d",
                           o_m_tuser, o_m_tdata[SymOutW-1:0]);
                    err_cnt++;
                end else begin
                    due = results_due.pop_front();
                    if (o_m_tuser !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, o_m_tuser);
                        err_cnt++;
                    end
                    if (o_m_tdata[SymOutW-1:0] !== due.symbol) begin
                        $error("symbol_out: expected %0d, got %0d",
                               due.symbol, o_m_tdata[SymOutW-1:0]);
                        err_cnt++;
                    end
                end
            end
            // A requested hold-off keeps ready low so the block backs up.
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (hold_done != hold_req) begin
                hold_done = hold_req;
                hold_left = HoldCycles;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: gives up when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= StallLimit) begin
                $display("tb_top: no word accepted for %0d cycles", StallLimit);
                $display("tb_top: done, errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic t_tree_word random_word(logic [ModeW-1:0] mode);
        t_tree_word w;
        w.mode       = mode;
        w.code       = CodeBitsW'($urandom_range(65535));
        w.len        = CodeLenW'($urandom_range(15));
        w.sym        = SymInW'($urandom_range(511));
        w.stream_bit = 1'($urandom_range(1));
        return w;
    endfunction

    task automatic queue_word(t_tree_word w);
        pending_words.push_back(w);
        words_queued++;
        if (w.mode != ModeUnused)
            stim_count++;
    endtask

    task automatic queue_insert(int unsigned code, int unsigned len, int unsigned sym);
        t_tree_word w;
        w      = random_word(MODE_INSERT);
        w.code = CodeBitsW'(code);
        w.len  = CodeLenW'(len);
        w.sym  = SymInW'(sym);
        queue_word(w);
    endtask

    task automatic queue_decode(int unsigned stream_bit);
        t_tree_word w;
        w            = random_word(MODE_DECODE);
        w.stream_bit = 1'(stream_bit);
        queue_word(w);
    endtask

    task automatic queue_clear();
        queue_word(random_word(MODE_CLEAR));
        known_codes.delete();
    endtask

    // Feeds the bits of a code as a run of decode words, first bit first.
    task automatic queue_code_walk(t_code_ref c);
        int i;
        for (i = 0; i < c.len; i++)
            queue_decode((c.code >> i) & 1);
    endtask

    // Inserts a fresh random code and keeps it for later decode runs.
    task automatic queue_new_code(bit long_only);
        t_code_ref c;
        int unsigned len;
        if (long_only || $urandom_range(1) == 1)
            len = $urandom_range(15, 10);
        else
            len = $urandom_range(15, 1);
        c.len  = CodeLenW'(len);
        c.code = CodeBitsW'($urandom_range(65535) & ((1 << len) - 1));
        c.sym  = SymInW'($urandom_range(511));
        queue_insert(c.code, c.len, c.sym);
        known_codes.push_back(c);
        if (known_codes.size() > KnownMax)
            void'(known_codes.pop_front());
    endtask

    // Waits until every queued word is taken and every predicted result has come.
    task automatic drain();
        while (words_accepted != words_queued || results_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_random(int send_pct, int stall_pct, int target);
        int start;
        int pick;
        int n;
        int unsigned len;
        int unsigned code;
        t_code_ref c;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        start = stim_count;
        while (stim_count - start < target) begin
            pick = $urandom_range(99);
            if (pick < 30 || (pick < 62 && known_codes.size() == 0)) begin
                queue_new_code(1'b0);
            end else if (pick < 62) begin
                // A well-formed decode run of a known code.
                queue_code_walk(known_codes[$urandom_range(known_codes.size() - 1)]);
            end else if (pick < 74) begin
                n = $urandom_range(6, 1);
                repeat (n) queue_decode($urandom_range(1));
            end else if (pick < 80 && known_codes.size() != 0) begin
                // Same code again, with its own symbol or a clashing one.
                c = known_codes[$urandom_range(known_codes.size() - 1)];
                if ($urandom_range(1) == 1)
                    c.sym = SymInW'($urandom_range(511));
                queue_insert(c.code, c.len, c.sym);
            end else if (pick < 88) begin
                // Bad length: zero, or a set bit at or above the length.
                len  = $urandom_range(15);
                code = $urandom_range(65535);
                if (len != 0)
                    code = code | (1 << $urandom_range(15, len));
                queue_insert(code, len, $urandom_range(511));
            end else if (pick < 94) begin
                queue_word(random_word(ModeUnused));
            end else if (pick < 96) begin
                queue_clear();
            end else begin
                queue_decode($urandom_range(1));
            end
        end
        drain();
    endtask

    initial begin : stimulus
        int i;
        tree_clear();
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, bad lengths, prefix conflicts, decodes, clear.
        queue_decode(0);
        queue_insert(0, 0, 1);
        queue_insert('b1000, 3, 2);
        queue_insert('hFFFF, 15, 3);
        queue_insert('b1, 1, 5);
        queue_insert('b00, 2, 0);
        queue_insert('b10, 2, 'h1FF);
        queue_insert('b10, 2, 'h1FF);
        queue_insert('b10, 2, 3);
        queue_insert('b11, 2, 7);
        queue_insert('b0, 1, 9);
        queue_decode(0);
        queue_decode(0);
        queue_decode(0);
        queue_decode(1);
        queue_decode(1);
        queue_word(random_word(ModeUnused));
        queue_clear();
        queue_decode(1);
        // An insert that lands while a decode walk is halfway down the tree.
        queue_insert('b111, 3, 'h155);
        queue_decode(1);
        queue_insert('b110, 3, 'h0AA);
        queue_decode(1);
        queue_decode(1);
        drain();

        // Fill the store with long codes behind a long receiver hold-off.
        hold_req++;
        queue_clear();
        repeat (90) queue_new_code(1'b1);
        for (i = 0; i < 3; i++)
            queue_code_walk(known_codes[known_codes.size() - 1 - i]);
        drain();

        run_random(0, 0, 345);
        run_random(59, 0, 345);
        run_random(0, 59, 345);
        run_random(8, 8, 345);

        repeat (TailCycles) @(negedge i_clk);
        $display("tb_top: %0d words sent (%0d of the unused mode), %0d results checked",
                 words_queued, words_queued - stim_count, results_seen);
        $display("tb_top: ins %0d, sym %0d, badlen %0d, ambig %0d, inval %0d, full %0d, clr %0d",
                 status_seen[ST_INSERTED], status_seen[ST_SYMBOL], status_seen[ST_BAD_LEN],
                 status_seen[ST_AMBIG], status_seen[ST_INVALID],
                 status_seen[ST_FULL], status_seen[ST_CLEARED]);
        if (err_cnt == 0 && results_due.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
